### src/fcdma_pkg.sv
package fcdma_pkg;

  localparam int unsigned LOW_CHAN_MAX_COUNT = 16384;
  localparam int unsigned TOP_CHAN_MAX_COUNT = 65536;
  localparam int unsigned FIFO_BURST         = 4;

  localparam int unsigned NUM_CHAN = 4;
  localparam int unsigned ADDR_W   = 28;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned REM_W    = 17;
  localparam int unsigned CTRL_W   = 16;

  localparam logic [ADDR_W-1:0] FIFO_A_ADDR = 28'h40000A0;
  localparam logic [ADDR_W-1:0] FIFO_B_ADDR = 28'h40000A4;

  localparam logic [2:0] K_IMM     = 3'd0;
  localparam logic [2:0] K_FIFO_A  = 3'd3;
  localparam logic [2:0] K_FIFO_B  = 3'd4;
  localparam logic [2:0] K_CAPTURE = 3'd5;
  localparam logic [2:0] K_INVALID = 3'd6;

  localparam logic [2:0] EV_LAST = 3'd4;

  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_HOLD = 2'd2;
  localparam logic [1:0] MODE_RELD = 2'd3;

  localparam logic [1:0] LANE_LO = 2'd0;
  localparam logic [1:0] LANE_HI = 2'd1;
  localparam logic [1:0] LANE_TOP = 2'd3;
  localparam logic [1:0] CHAN_TOP = 2'd3;

  typedef enum logic [2:0] {
    OP_SRC_WR  = 3'd0,
    OP_DST_WR  = 3'd1,
    OP_CNT_WR  = 3'd2,
    OP_CTRL_WR = 3'd3,
    OP_CTRL_RD = 3'd4,
    OP_EVENT   = 3'd5,
    OP_STEP    = 3'd6,
    OP_CAP_OFF = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] ch;
    logic [1:0] lane;
    logic [7:0] data;
    logic       ev_ok;
    logic [2:0] ev_kind;
  } item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              xfer_valid;
    logic [1:0]        xfer_channel;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic              word_size;
    logic              block_end;
    logic              irq_valid;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  function automatic logic [ADDR_W-1:0] byte_merge(input logic [ADDR_W-1:0] r,
                                                   input logic [1:0] lane,
                                                   input logic [7:0] v);
    logic [ADDR_W-1:0] res;
    res = r;
    case (lane)
      2'd0:    res[7:0]   = v;
      2'd1:    res[15:8]  = v;
      2'd2:    res[23:16] = v;
      default: res[27:24] = v[3:0];
    endcase
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] step_addr(input logic [ADDR_W-1:0] a,
                                                  input logic [1:0] mode,
                                                  input logic word);
    logic [ADDR_W-1:0] sz;
    sz = word ? ADDR_W'(4) : ADDR_W'(2);
    if (mode == MODE_DEC) return a - sz;
    if (mode == MODE_HOLD) return a;
    return a + sz;
  endfunction

endpackage

### src/four_channel_dma_controller_core.sv
// channel | direction | ports
// in      | input     | in_valid/in_ready, opcode, channel, byte_index, data_byte, event_kind
// out     | output    | out_valid/out_ready, read_data, xfer_*, addrs, word_size, block_end, irq
//
// One beat in, one beat out; each beat is registered in the queue and then in the output register.
// The block sustains one beat per cycle while out_ready stays high.
// A two-entry queue sits between decode and execution; in_ready drops when it is full.
// The output register holds a result while out_ready is low; execution stalls behind it.
// Synchronous active-low reset clears all channel state; no channel active.
module four_channel_dma_controller_core #(
  parameter int unsigned LOW_CHAN_MAX_COUNT = fcdma_pkg::LOW_CHAN_MAX_COUNT,
  parameter int unsigned TOP_CHAN_MAX_COUNT = fcdma_pkg::TOP_CHAN_MAX_COUNT,
  parameter int unsigned FIFO_BURST         = fcdma_pkg::FIFO_BURST
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_channel,
  input  logic [1:0]  in_byte_index,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  in_event_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_xfer_valid,
  output logic [1:0]  out_xfer_channel,
  output logic [27:0] out_src_addr,
  output logic [27:0] out_dst_addr,
  output logic        out_word_size,
  output logic        out_block_end,
  output logic        out_irq_valid
);

  logic               q_full, q_push, q_pop, q_head_valid;
  fcdma_pkg::item_t   q_in_item, q_head_item;
  fcdma_pkg::hs_t     out_hs;
  fcdma_pkg::result_t res;

  fcdma_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_channel    (in_channel),
    .in_byte_index (in_byte_index),
    .in_data_byte  (in_data_byte),
    .in_event_kind (in_event_kind),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  fcdma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  fcdma_back #(
    .LOW_CHAN_MAX_COUNT (LOW_CHAN_MAX_COUNT),
    .TOP_CHAN_MAX_COUNT (TOP_CHAN_MAX_COUNT),
    .FIFO_BURST         (FIFO_BURST)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop),
    .out_hs_o   (out_hs),
    .out_ready  (out_ready),
    .res_o      (res)
  );

  assign out_valid        = out_hs.valid;
  assign out_read_data    = res.read_data;
  assign out_xfer_valid   = res.xfer_valid;
  assign out_xfer_channel = res.xfer_channel;
  assign out_src_addr     = res.src_addr;
  assign out_dst_addr     = res.dst_addr;
  assign out_word_size    = res.word_size;
  assign out_block_end    = res.block_end;
  assign out_irq_valid    = res.irq_valid;

endmodule

### src/fcdma_front.sv
module fcdma_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  logic [1:0]        in_channel,
  input  logic [1:0]        in_byte_index,
  input  logic [7:0]        in_data_byte,
  input  logic [2:0]        in_event_kind,
  input  logic              q_full,
  output logic              q_push,
  output fcdma_pkg::item_t  q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.op      = fcdma_pkg::op_t'(in_opcode);
    q_item.ch      = in_channel;
    q_item.lane    = in_byte_index;
    q_item.data    = in_data_byte;
    q_item.ev_ok   = (in_event_kind <= fcdma_pkg::EV_LAST);
    q_item.ev_kind = in_event_kind + 3'd1;
  end

endmodule

### src/fcdma_queue.sv
module fcdma_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fcdma_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output fcdma_pkg::item_t head_item
);

  fcdma_pkg::item_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### src/fcdma_back.sv
module fcdma_back #(
  parameter int unsigned LOW_CHAN_MAX_COUNT = fcdma_pkg::LOW_CHAN_MAX_COUNT,
  parameter int unsigned TOP_CHAN_MAX_COUNT = fcdma_pkg::TOP_CHAN_MAX_COUNT,
  parameter int unsigned FIFO_BURST         = fcdma_pkg::FIFO_BURST
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  fcdma_pkg::item_t  head_item,
  output logic              pop,
  output fcdma_pkg::hs_t    out_hs_o,
  input  logic              out_ready,
  output fcdma_pkg::result_t res_o
);

  localparam logic [15:0] LOW_MASK = 16'(LOW_CHAN_MAX_COUNT - 1);
  localparam logic [15:0] TOP_MASK = 16'(TOP_CHAN_MAX_COUNT - 1);
  localparam logic [16:0] LOW_MAX  = 17'(LOW_CHAN_MAX_COUNT);
  localparam logic [16:0] TOP_MAX  = 17'(TOP_CHAN_MAX_COUNT);
  localparam logic [16:0] BURST    = 17'(FIFO_BURST);

  logic [27:0] src_reg_r  [4], src_reg_nxt  [4];
  logic [27:0] dst_reg_r  [4], dst_reg_nxt  [4];
  logic [15:0] cnt_reg_r  [4], cnt_reg_nxt  [4];
  logic [27:0] src_work_r [4], src_work_nxt [4];
  logic [27:0] dst_work_r [4], dst_work_nxt [4];
  logic [16:0] rem_r      [4], rem_nxt      [4];
  logic [15:0] ctrl_r     [4], ctrl_nxt     [4];
  logic [3:0]  pend_r, pend_nxt;
  logic [2:0]  act_r, act_nxt;
  logic        out_valid_r, out_valid_nxt;
  fcdma_pkg::result_t res_r, res_nxt;
  logic        fire;

  assign fire          = head_valid && (!out_valid_r || out_ready);
  assign pop           = fire;
  assign out_valid_nxt = fire || (out_valid_r && !out_ready);
  assign out_hs_o.valid = out_valid_r;
  assign out_hs_o.ready = out_ready;
  assign res_o         = res_r;

  always_comb begin
    logic [1:0]  ch;
    logic [1:0]  a;
    logic [2:0]  kind;
    logic        was_on;
    logic        start;
    logic        found;
    logic [15:0] c;
    logic [15:0] cval;
    logic        fifo;
    logic        word;
    logic [27:0] cur_dst;
    logic [16:0] cur_rem;
    src_reg_nxt  = src_reg_r;
    dst_reg_nxt  = dst_reg_r;
    cnt_reg_nxt  = cnt_reg_r;
    src_work_nxt = src_work_r;
    dst_work_nxt = dst_work_r;
    rem_nxt      = rem_r;
    ctrl_nxt     = ctrl_r;
    pend_nxt     = pend_r;
    act_nxt      = act_r;
    res_nxt      = res_r;
    ch = head_item.ch;
    a = 2'd0; kind = fcdma_pkg::K_IMM; was_on = 1'b0; start = 1'b0; found = 1'b0;
    c = '0; cval = '0; fifo = 1'b0; word = 1'b0; cur_dst = '0; cur_rem = '0;
    if (fire) begin
      res_nxt = '0;
      unique case (head_item.op)
        fcdma_pkg::OP_SRC_WR: begin
          src_reg_nxt[ch] = fcdma_pkg::byte_merge(src_reg_r[ch], head_item.lane, head_item.data);
        end
        fcdma_pkg::OP_DST_WR: begin
          dst_reg_nxt[ch] = fcdma_pkg::byte_merge(dst_reg_r[ch], head_item.lane, head_item.data);
          if (ch != fcdma_pkg::CHAN_TOP) dst_reg_nxt[ch][27] = 1'b0;
        end
        fcdma_pkg::OP_CNT_WR: begin
          if (head_item.lane == fcdma_pkg::LANE_LO || head_item.lane == fcdma_pkg::LANE_HI) begin
            cval = cnt_reg_r[ch];
            if (head_item.lane == fcdma_pkg::LANE_LO) cval[7:0] = head_item.data;
            else cval[15:8] = head_item.data;
            cnt_reg_nxt[ch] = cval & ((ch == fcdma_pkg::CHAN_TOP) ? TOP_MASK : LOW_MASK);
          end
        end
        fcdma_pkg::OP_CTRL_WR: begin
          if (head_item.lane == fcdma_pkg::LANE_LO) begin
            ctrl_nxt[ch] = (ctrl_r[ch] & 16'hFF1F) | {8'h00, head_item.data & 8'hE0};
          end else if (head_item.lane == fcdma_pkg::LANE_HI) begin
            was_on = ctrl_r[ch][15];
            kind = {1'b0, head_item.data[5:4]};
            if (head_item.data[5:4] == 2'd3) begin
              if (ch == 2'd0) kind = fcdma_pkg::K_INVALID;
              else if (ch == fcdma_pkg::CHAN_TOP) kind = fcdma_pkg::K_CAPTURE;
              else if (dst_reg_r[ch] == fcdma_pkg::FIFO_A_ADDR) kind = fcdma_pkg::K_FIFO_A;
              else if (dst_reg_r[ch] == fcdma_pkg::FIFO_B_ADDR) kind = fcdma_pkg::K_FIFO_B;
              else kind = fcdma_pkg::K_INVALID;
            end
            ctrl_nxt[ch] = {head_item.data, ctrl_r[ch][7:5], 2'b00, kind};
            if (!was_on && head_item.data[7]) begin
              src_work_nxt[ch] = src_reg_r[ch];
              dst_work_nxt[ch] = dst_reg_r[ch];
              if (kind == fcdma_pkg::K_IMM) begin
                for (int i = 0; i < 4; i++) begin
                  if (ctrl_nxt[i][15] && ctrl_nxt[i][2:0] == fcdma_pkg::K_IMM) pend_nxt[i] = 1'b1;
                end
              end
            end
          end
        end
        fcdma_pkg::OP_CTRL_RD: begin
          if (head_item.lane == fcdma_pkg::LANE_LO) res_nxt.read_data = ctrl_r[ch][7:0] & 8'hE0;
          else if (head_item.lane == fcdma_pkg::LANE_HI) res_nxt.read_data = ctrl_r[ch][15:8];
        end
        fcdma_pkg::OP_EVENT: begin
          if (head_item.ev_ok) begin
            for (int i = 0; i < 4; i++) begin
              if (ctrl_r[i][15] && ctrl_r[i][2:0] == head_item.ev_kind) pend_nxt[i] = 1'b1;
            end
          end
        end
        fcdma_pkg::OP_CAP_OFF: begin
          if (ctrl_r[3][2:0] == fcdma_pkg::K_CAPTURE) ctrl_nxt[3][15] = 1'b0;
        end
        fcdma_pkg::OP_STEP: begin
          if (act_r[2]) begin
            for (int i = 3; i >= 0; i--) begin
              if (pend_r[i]) begin
                a = 2'(i);
                found = 1'b1;
              end
            end
            start = found;
          end else begin
            a = act_r[1:0];
            found = 1'b1;
          end
          if (found) begin
            c = ctrl_r[a];
            fifo = (c[2:0] == fcdma_pkg::K_FIFO_A) || (c[2:0] == fcdma_pkg::K_FIFO_B);
            word = fifo || c[10];
            cur_dst = (start && c[6:5] == fcdma_pkg::MODE_RELD) ? dst_reg_r[a] : dst_work_r[a];
            if (start) begin
              if (fifo) cur_rem = BURST;
              else if (cnt_reg_r[a] == 16'd0)
                cur_rem = (a == fcdma_pkg::CHAN_TOP) ? TOP_MAX : LOW_MAX;
              else cur_rem = {1'b0, cnt_reg_r[a]};
            end else begin
              cur_rem = rem_r[a];
            end
            res_nxt.xfer_valid   = 1'b1;
            res_nxt.xfer_channel = a;
            res_nxt.src_addr     = src_work_r[a];
            res_nxt.dst_addr     = cur_dst;
            res_nxt.word_size    = word;
            if (c[8:7] != 2'd3)
              src_work_nxt[a] = fcdma_pkg::step_addr(src_work_r[a], c[8:7], word);
            dst_work_nxt[a] = fifo ? cur_dst : fcdma_pkg::step_addr(cur_dst, c[6:5], word);
            if (cur_rem <= 17'd1) begin
              rem_nxt[a]        = '0;
              res_nxt.block_end = 1'b1;
              res_nxt.irq_valid = c[14];
              if (!c[9] || c[2:0] == fcdma_pkg::K_IMM || c[11]) ctrl_nxt[a][15] = 1'b0;
              pend_nxt[a] = 1'b0;
              act_nxt     = 3'b100;
            end else begin
              rem_nxt[a] = cur_rem - 17'd1;
              act_nxt    = {1'b0, a};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        src_reg_r[i]  <= '0;
        dst_reg_r[i]  <= '0;
        cnt_reg_r[i]  <= '0;
        src_work_r[i] <= '0;
        dst_work_r[i] <= '0;
        rem_r[i]      <= '0;
        ctrl_r[i]     <= '0;
      end
      pend_r      <= '0;
      act_r       <= 3'b100;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      src_reg_r   <= src_reg_nxt;
      dst_reg_r   <= dst_reg_nxt;
      cnt_reg_r   <= cnt_reg_nxt;
      src_work_r  <= src_work_nxt;
      dst_work_r  <= dst_work_nxt;
      rem_r       <= rem_nxt;
      ctrl_r      <= ctrl_nxt;
      pend_r      <= pend_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

### src/fcdma_checker.sv
module fcdma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic        out_xfer_valid,
  input logic [1:0]  out_xfer_channel,
  input logic [27:0] out_src_addr,
  input logic [27:0] out_dst_addr,
  input logic        out_word_size,
  input logic        out_block_end,
  input logic        out_irq_valid
);

  a_irq_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_valid |-> out_block_end)
    else $error("irq without block end");

  a_end_is_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_xfer_valid)
    else $error("block end without access");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_xfer_valid |-> out_src_addr == 28'd0 && out_dst_addr == 28'd0
      && out_xfer_channel == 2'd0 && !out_word_size)
    else $error("idle beat carries access fields");

  a_read_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'd0 |-> !out_xfer_valid)
    else $error("read data on access beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_addr) && $stable(out_dst_addr))
    else $error("stalled beat changed");

endmodule

bind four_channel_dma_controller_core fcdma_checker u_fcdma_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_read_data    (out_read_data),
  .out_xfer_valid   (out_xfer_valid),
  .out_xfer_channel (out_xfer_channel),
  .out_src_addr     (out_src_addr),
  .out_dst_addr     (out_dst_addr),
  .out_word_size    (out_word_size),
  .out_block_end    (out_block_end),
  .out_irq_valid    (out_irq_valid)
);
